[rtl/cta_pkg.sv]
`timescale 1ns / 1ps

package cta_pkg;

    // Field widths
    localparam int TARGET_W   = 10;
    localparam int COUNT_W    = 10;
    localparam int PEERS_W    = 8;
    localparam int TOTAL_W    = COUNT_W + 1;
    localparam int INTERVAL_W = 12;
    localparam int JITTER_W   = 10;
    localparam int SILENT_W   = 2;

    // Shared divider sizing: interval * (5*total + 2*T) fits 26 bits, 5*T fits 13 bits
    localparam int MIX_W      = 14;
    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 13;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Interval limits and defaults, ms
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 12'd875;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX    = 12'd4000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MIN    = 12'd150;
    localparam logic [INTERVAL_W-1:0] SILENT_DEFAULT  = 12'd1000;
    localparam logic [INTERVAL_W-1:0] NO_PEER_MIN     = 12'd1000;
    localparam logic [INTERVAL_W-1:0] SLOW_ZERO_FLOOR = 12'd50;
    localparam logic [INTERVAL_W-1:0] BIG_STEP_LIMIT  = 12'd300;
    localparam logic [JITTER_W-1:0]   JITTER_RESET    = 10'd250;
    localparam logic [JITTER_W-1:0]   JITTER_MIN      = 10'd25;
    localparam logic [TARGET_W-1:0]   TARGET_RESET    = 10'd20;

    // Speed-up step sizes, ms
    localparam logic [INTERVAL_W-1:0] ADJ_DEFAULT = 12'd10;
    localparam logic [INTERVAL_W-1:0] ADJ_MEDIUM  = 12'd20;
    localparam logic [INTERVAL_W-1:0] ADJ_LARGE   = 12'd50;
    localparam logic [INTERVAL_W-1:0] ADJ_FINE    = 12'd3;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/cta_divider.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. done pulses with the quotient valid.
module cta_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  cta_pkg::div_req_t  req,
    output cta_pkg::div_rsp_t  rsp
);

    logic [cta_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [cta_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic                           done_reg;
    logic                           done_next;
    logic [cta_pkg::DIVIDEND_W-1:0] quot_reg;
    logic [cta_pkg::DIVIDEND_W-1:0] quot_next;
    logic [cta_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [cta_pkg::DIVISOR_W-1:0]  rem_next;
    logic [cta_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [cta_pkg::DIVISOR_W-1:0]  dsr_next;
    logic [cta_pkg::DIVISOR_W:0]    trial;
    logic [cta_pkg::DIVISOR_W:0]    diff;
    logic                           ge;

    assign trial = {rem_reg, quot_reg[cta_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            cnt_next  = cta_pkg::DIV_CNT_W'(cta_pkg::DIV_STEPS);
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == cta_pkg::DIV_CNT_W'(1));
            quot_next = {quot_reg[cta_pkg::DIVIDEND_W-2:0], ge};
            // remainder stays below the divisor, so the top bit drops
            rem_next  = ge ? diff[cta_pkg::DIVISOR_W-1:0] : trial[cta_pkg::DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

[rtl/congestion_tx_interval_adapter.sv]
`timescale 1ns / 1ps

// Path per window: halving or holding goes through ST_CMP and ST_FIN; speeding up with no
//   peers adds ST_APPLY; slowing down goes through ST_MUL and ST_DIV3; speeding up with peers
//   goes through ST_DIV1, ST_DIV2 (skipped when the per-peer share is zero) and ST_APPLY.
//   The divide states use the shared 26-step serial divider. Flow control: one window at a time,
//   s_axis_tready high only while idle; ST_FIN waits while a result word waits for m_axis_tready.
// Reset (rst_n, async, active low): interval 875 ms, jitter 250 ms, silence 0, target 20.
module congestion_tx_interval_adapter
(
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration: target_per_window
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cta_pkg::TARGET_W-1:0]     cfg_data,

    // Window word in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // others_seen[9:0], own_sent[19:10],
                                                            // peer_count[27:20], zero pad

    // Result word out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // tx_interval_ms[11:0],
                                                            // jitter_ms[21:12], zero pad
    output logic [0:0]                       m_axis_tuser   // reset_radio[0]
);

    // Sequencer, one-hot
    typedef enum logic [7:0]
    {
        ST_IDLE  = 8'b0000_0001,   // waiting for a window word
        ST_CMP   = 8'b0000_0010,   // ratio tests, pick path
        ST_DIV1  = 8'b0000_0100,   // share = T / peers
        ST_DIV2  = 8'b0000_1000,   // minimum = 4000 / share
        ST_APPLY = 8'b0001_0000,   // raise interval to minimum
        ST_MUL   = 8'b0010_0000,   // interval * (5*total + 2*T), start divide by 5*T
        ST_DIV3  = 8'b0100_0000,   // slow-down quotient
        ST_FIN   = 8'b1000_0000    // silence rules, jitter, write result
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Control state
    logic [cta_pkg::TARGET_W-1:0]   target_reg;
    logic [cta_pkg::TARGET_W-1:0]   target_next;
    logic [cta_pkg::INTERVAL_W-1:0] interval_reg;
    logic [cta_pkg::INTERVAL_W-1:0] interval_next;
    logic [cta_pkg::JITTER_W-1:0]   jitter_reg;
    logic [cta_pkg::JITTER_W-1:0]   jitter_next;
    logic [cta_pkg::SILENT_W-1:0]   silent_reg;
    logic [cta_pkg::SILENT_W-1:0]   silent_next;
    logic                           radio_reg;
    logic                           radio_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // Working payload
    logic [cta_pkg::COUNT_W-1:0]    others_reg;
    logic [cta_pkg::COUNT_W-1:0]    others_next;
    logic [cta_pkg::COUNT_W-1:0]    own_reg;
    logic [cta_pkg::COUNT_W-1:0]    own_next;
    logic [cta_pkg::PEERS_W-1:0]    peers_reg;
    logic [cta_pkg::PEERS_W-1:0]    peers_next;
    logic [cta_pkg::INTERVAL_W-1:0] work_reg;
    logic [cta_pkg::INTERVAL_W-1:0] work_next;
    logic [cta_pkg::INTERVAL_W-1:0] floor_reg;
    logic [cta_pkg::INTERVAL_W-1:0] floor_next;

    // Datapath helpers
    logic [cta_pkg::TARGET_W-1:0]   t_eff;
    logic [cta_pkg::TOTAL_W-1:0]    total;
    logic [15:0]                    tot16;
    logic [15:0]                    t16;
    logic                           speed_up;
    logic                           quarter;
    logic                           four_fifths;
    logic                           half;
    logic                           near;
    logic                           slow_down;
    logic                           big_iv;
    logic [cta_pkg::INTERVAL_W-1:0] adjust;
    logic [cta_pkg::INTERVAL_W-1:0] iv_sub;
    logic [cta_pkg::MIX_W-1:0]      mix;
    logic [cta_pkg::DIVISOR_W-1:0]  five_t;
    logic [cta_pkg::DIVIDEND_W-1:0] product;
    logic [cta_pkg::DIVIDEND_W-1:0] quot;
    logic [cta_pkg::INTERVAL_W-1:0] iv_fin;
    logic [cta_pkg::JITTER_W-1:0]   jit_raw;
    logic                           out_free;
    logic                           in_accept;

    cta_pkg::div_req_t div_req;
    cta_pkg::div_rsp_t div_rsp;

    cta_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A zero target counts as one
    assign t_eff = (target_reg == '0) ? cta_pkg::TARGET_W'(1) : target_reg;
    assign total = cta_pkg::TOTAL_W'(others_reg) + cta_pkg::TOTAL_W'(own_reg);
    assign tot16 = 16'(total);
    assign t16   = 16'(t_eff);

    // Ratio tests as exact cross products
    assign speed_up    = (tot16 * 16'd20) < (t16 * 16'd19);
    assign quarter     = (tot16 * 16'd4)  < t16;
    assign four_fifths = (tot16 * 16'd5)  < (t16 * 16'd4);
    assign half        = (tot16 * 16'd2)  < t16;
    assign near        = (tot16 * 16'd10) > (t16 * 16'd9);
    assign slow_down   = tot16 > t16;
    assign big_iv      = interval_reg > cta_pkg::BIG_STEP_LIMIT;

    // Step size: later tests win
    always_comb
    begin
        adjust = cta_pkg::ADJ_DEFAULT;
        if (four_fifths && big_iv)
        begin
            adjust = cta_pkg::ADJ_MEDIUM;
        end
        if (half && big_iv)
        begin
            adjust = cta_pkg::ADJ_LARGE;
        end
        if (near)
        begin
            adjust = cta_pkg::ADJ_FINE;
        end
    end

    // Only step down when we are not the main talker
    always_comb
    begin
        iv_sub = interval_reg;
        if (own_reg <= others_reg)
        begin
            iv_sub = (interval_reg > adjust) ? (interval_reg - adjust) : '0;
        end
    end

    assign mix     = cta_pkg::MIX_W'(total) * cta_pkg::MIX_W'(5)
                   + cta_pkg::MIX_W'(t_eff) * cta_pkg::MIX_W'(2);
    assign five_t  = cta_pkg::DIVISOR_W'(t_eff) * cta_pkg::DIVISOR_W'(5);
    assign product = cta_pkg::DIVIDEND_W'(interval_reg) * cta_pkg::DIVIDEND_W'(mix);
    assign quot    = div_rsp.quotient;

    // Silent window forces the default; jitter is taken before the 150 ms floor
    assign iv_fin  = (others_reg == '0) ? cta_pkg::SILENT_DEFAULT : work_reg;
    assign jit_raw = iv_fin[cta_pkg::INTERVAL_W-1:2];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        interval_next  = interval_reg;
        jitter_next    = jitter_reg;
        silent_next    = silent_reg;
        radio_next     = radio_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        others_next    = others_reg;
        own_next       = own_reg;
        peers_next     = peers_reg;
        work_next      = work_reg;
        floor_next     = floor_reg;
        div_req        = '0;

        if (cfg_valid)
        begin
            target_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    others_next = s_axis_tdata[9:0];
                    own_next    = s_axis_tdata[19:10];
                    peers_next  = s_axis_tdata[27:20];
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                priority if (speed_up && quarter)
                begin
                    work_next  = {1'b0, interval_reg[cta_pkg::INTERVAL_W-1:1]};
                    state_next = ST_FIN;
                end
                else if (speed_up)
                begin
                    work_next = iv_sub;
                    if (peers_reg == '0)
                    begin
                        floor_next = cta_pkg::NO_PEER_MIN;
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = cta_pkg::DIVIDEND_W'(t_eff);
                        div_req.divisor  = cta_pkg::DIVISOR_W'(peers_reg);
                        state_next       = ST_DIV1;
                    end
                end
                else if (slow_down)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    work_next  = interval_reg;
                    state_next = ST_FIN;
                end
            end
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if (quot == '0)
                    begin
                        // share rounds to nothing
                        floor_next = cta_pkg::INTERVAL_MAX;
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = cta_pkg::DIVIDEND_W'(cta_pkg::INTERVAL_MAX);
                        div_req.divisor  = quot[cta_pkg::DIVISOR_W-1:0];
                        state_next       = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_rsp.done)
                begin
                    floor_next = quot[cta_pkg::INTERVAL_W-1:0];
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (work_reg < floor_reg)
                begin
                    work_next = floor_reg;
                end
                state_next = ST_FIN;
            end
            ST_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = product;
                div_req.divisor  = five_t;
                state_next       = ST_DIV3;
            end
            ST_DIV3:
            begin
                if (div_rsp.done)
                begin
                    priority if (quot == '0)
                    begin
                        work_next = cta_pkg::SLOW_ZERO_FLOOR;
                    end
                    else if (quot > cta_pkg::DIVIDEND_W'(cta_pkg::INTERVAL_MAX))
                    begin
                        work_next = cta_pkg::INTERVAL_MAX;
                    end
                    else
                    begin
                        work_next = quot[cta_pkg::INTERVAL_W-1:0];
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // wait here while the previous result is still unread
                if (out_free)
                begin
                    jitter_next   = (jit_raw < cta_pkg::JITTER_MIN) ? cta_pkg::JITTER_MIN
                                                                    : jit_raw;
                    interval_next = (iv_fin < cta_pkg::INTERVAL_MIN) ? cta_pkg::INTERVAL_MIN
                                                                     : iv_fin;
                    radio_next    = 1'b0;
                    priority if (others_reg != '0)
                    begin
                        silent_next = '0;
                    end
                    else if (silent_reg == '1)
                    begin
                        silent_next = '0;
                        radio_next  = 1'b1;
                    end
                    else
                    begin
                        silent_next = silent_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= cta_pkg::TARGET_RESET;
            interval_reg  <= cta_pkg::INTERVAL_RESET;
            jitter_reg    <= cta_pkg::JITTER_RESET;
            silent_reg    <= '0;
            radio_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            interval_reg  <= interval_next;
            jitter_reg    <= jitter_next;
            silent_reg    <= silent_next;
            radio_reg     <= radio_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        others_reg <= others_next;
        own_reg    <= own_next;
        peers_reg  <= peers_next;
        work_reg   <= work_next;
        floor_reg  <= floor_next;
    end

    // Interval and jitter state only move in ST_FIN, once the result word has gone
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, jitter_reg, interval_reg};
    assign m_axis_tuser  = radio_reg;

endmodule

[rtl/cta_checker.sv]
`timescale 1ns / 1ps

module cta_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One window in flight
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_iv_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:0] >= 12'd150) && (m_axis_tdata[11:0] <= 12'd4000)
                          && (m_axis_tdata[21:12] >= 10'd25))
        else $error("interval or jitter out of range");

    // Above the floor, jitter is a quarter of the interval
    a_jitter_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[11:0] > 12'd150) |->
            m_axis_tdata[21:12] == m_axis_tdata[11:2])
        else $error("jitter not a quarter of interval");

endmodule

bind congestion_tx_interval_adapter cta_checker u_cta_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;     // quiet cycles before a target write
    localparam int HOLD_CYCLES   = 400;   // long back-pressure stretch on the result side
    localparam int TAIL_CYCLES   = 100;   // run-on after the last result word, well past the slowest window
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_WINDOWS = 110;

    typedef enum logic [1:0] {ACT_WINDOW, ACT_TARGET, ACT_DRAIN} action_t;

    // One entry of the sender's work list
    typedef struct {
        action_t                      kind;
        logic [cta_pkg::COUNT_W-1:0]  others;
        logic [cta_pkg::COUNT_W-1:0]  own;
        logic [cta_pkg::PEERS_W-1:0]  peers;
        logic [cta_pkg::TARGET_W-1:0] target;
        int                           gap;
    } tick_t;

    // Pacing that one window should produce
    typedef struct packed {
        logic [cta_pkg::INTERVAL_W-1:0] interval;
        logic [cta_pkg::JITTER_W-1:0]   jitter;
        logic                           reset_radio;
    } pace_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [cta_pkg::TARGET_W-1:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Shadow copy of the block's state and its target register
    logic [cta_pkg::TARGET_W-1:0]   model_target   = cta_pkg::TARGET_RESET;
    logic [cta_pkg::INTERVAL_W-1:0] model_interval = cta_pkg::INTERVAL_RESET;
    logic [cta_pkg::JITTER_W-1:0]   model_jitter   = cta_pkg::JITTER_RESET;
    logic [cta_pkg::SILENT_W-1:0]   model_silent   = '0;

    tick_t pending_ticks[$];
    pace_t expected_pacing[$];
    tick_t cur_tick;
    bit    have_tick = 1'b0;
    int    tx_wait   = 0;
    int    settle    = SETTLE_CYCLES;
    int    tx_mode_left = 0;
    bit    tx_steady = 1'b0;

    int    rx_wait      = 0;
    int    hold_left    = 0;
    int    rx_mode_left = 0;
    bit    rx_steady    = 1'b0;
    int    n_results    = 0;
    int    fail_count   = 0;

    congestion_tx_interval_adapter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // Works out the pacing for one window and moves the shadow state on.
    // Ratio tests against the target are cross-multiplied, as in the block.
    function automatic pace_t advance_pacing(input logic [cta_pkg::COUNT_W-1:0] others,
                                             input logic [cta_pkg::COUNT_W-1:0] own,
                                             input logic [cta_pkg::PEERS_W-1:0] peers);
        int unsigned t;
        int unsigned total;
        int unsigned iv;
        int unsigned adjust;
        int unsigned floor_iv;
        int unsigned share;
        int unsigned scaled;
        int unsigned jit;
        pace_t       res;

        t     = (model_target == 0) ? 1 : model_target;   // zero target acts as one
        total = others + own;
        iv    = model_interval;
        res.reset_radio = 1'b0;

        if (20 * total < 19 * t)
        begin
            if (4 * total < t)
                iv = iv / 2;
            else
            begin
                adjust = cta_pkg::ADJ_DEFAULT;
                if (5 * total < 4 * t && iv > cta_pkg::BIG_STEP_LIMIT)
                    adjust = cta_pkg::ADJ_MEDIUM;
                if (2 * total < t && iv > cta_pkg::BIG_STEP_LIMIT)
                    adjust = cta_pkg::ADJ_LARGE;
                if (10 * total > 9 * t)
                    adjust = cta_pkg::ADJ_FINE;
                // only back off the interval when we are not the busy one
                if (own <= others)
                    iv = (iv > adjust) ? iv - adjust : 0;
                if (peers == 0)
                    floor_iv = cta_pkg::NO_PEER_MIN;
                else
                begin
                    share    = t / peers;
                    floor_iv = (share == 0) ? cta_pkg::INTERVAL_MAX
                                            : cta_pkg::INTERVAL_MAX / share;
                end
                if (iv < floor_iv)
                    iv = floor_iv;
            end
        end
        else if (total > t)
        begin
            scaled = (iv * (5 * total + 2 * t)) / (5 * t);
            if (scaled == 0)
                scaled = cta_pkg::SLOW_ZERO_FLOOR;
            if (scaled > cta_pkg::INTERVAL_MAX)
                scaled = cta_pkg::INTERVAL_MAX;
            iv = scaled;
        end

        if (others == 0)
            iv = cta_pkg::SILENT_DEFAULT;

        // jitter is taken before the lower clamp of the interval
        jit = iv >> 2;
        if (jit < cta_pkg::JITTER_MIN)
            jit = cta_pkg::JITTER_MIN;
        if (iv < cta_pkg::INTERVAL_MIN)
            iv = cta_pkg::INTERVAL_MIN;
        if (iv > cta_pkg::INTERVAL_MAX)
            iv = cta_pkg::INTERVAL_MAX;

        model_interval = iv[cta_pkg::INTERVAL_W-1:0];
        model_jitter   = jit[cta_pkg::JITTER_W-1:0];

        // fourth silent window in a row asks for a radio reset
        if (others != 0)
            model_silent = '0;
        else if (model_silent >= 3)
        begin
            model_silent    = '0;
            res.reset_radio = 1'b1;
        end
        else
            model_silent = model_silent + 1'b1;

        res.interval = model_interval;
        res.jitter   = model_jitter;
        return res;
    endfunction

    task automatic add_window(input int others, input int own, input int peers);
        tick_t tk;
        // sender switches at random between gappy stretches and back-to-back stretches
        if (tx_mode_left == 0)
        begin
            tx_steady    = ($urandom_range(0, 2) == 0);
            tx_mode_left = $urandom_range(10, 50);
        end
        tx_mode_left--;
        tk.kind   = ACT_WINDOW;
        tk.others = others[cta_pkg::COUNT_W-1:0];
        tk.own    = own[cta_pkg::COUNT_W-1:0];
        tk.peers  = peers[cta_pkg::PEERS_W-1:0];
        tk.target = '0;
        tk.gap    = tx_steady ? 0 : $urandom_range(0, 14);
        pending_ticks.push_back(tk);
    endtask

    task automatic add_control(input action_t kind, input int target);
        tick_t tk;
        tk.kind   = kind;
        tk.others = '0;
        tk.own    = '0;
        tk.peers  = '0;
        tk.target = target[cta_pkg::TARGET_W-1:0];
        tk.gap    = 0;
        pending_ticks.push_back(tk);
    endtask

    // Sender: window words and target writes, in list order. Target writes
    // and drain marks wait until every expected word is back and the settle
    // countdown has run out.
    always @(posedge clk or negedge rst_n)
    begin : send_block
        logic take_window;
        logic take_target;
        logic next_valid;
        logic next_cfg;

        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid     <= 1'b0;
        end
        else
        begin
            take_window = s_axis_tvalid && s_axis_tready;
            take_target = cfg_valid && cfg_ready;
            if (take_window)
                expected_pacing.push_back(advance_pacing(s_axis_tdata[9:0],
                                                         s_axis_tdata[19:10],
                                                         s_axis_tdata[27:20]));
            if (take_target)
                model_target = cfg_data;
            next_valid = s_axis_tvalid && !take_window;
            next_cfg   = cfg_valid && !take_target;

            if (expected_pacing.size() != 0 || s_axis_tvalid || cfg_valid)
                settle = SETTLE_CYCLES;
            else if (settle > 0)
                settle--;

            if (!next_valid && !next_cfg)
            begin
                if (!have_tick && pending_ticks.size() != 0)
                begin
                    cur_tick  = pending_ticks.pop_front();
                    have_tick = 1'b1;
                    tx_wait   = cur_tick.gap;
                end
                if (have_tick)
                begin
                    case (cur_tick.kind)
                        ACT_WINDOW:
                        begin
                            if (tx_wait > 0)
                                tx_wait--;
                            else
                            begin
                                next_valid   = 1'b1;
                                s_axis_tdata <= {4'd0, cur_tick.peers, cur_tick.own,
                                                 cur_tick.others};
                                have_tick    = 1'b0;
                            end
                        end
                        ACT_TARGET:
                        begin
                            if (settle == 0)
                            begin
                                next_cfg  = 1'b1;
                                cfg_data  <= cur_tick.target;
                                have_tick = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (settle == 0)
                                have_tick = 1'b0;
                        end
                    endcase
                end
            end
            s_axis_tvalid <= next_valid;
            cfg_valid     <= next_cfg;
        end
    end

    // Receiver: checks each result word against the oldest expectation and
    // stalls at random once a word is showing; twice it holds off for a long
    // stretch so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin : check_block
        pace_t want;
        logic  bad;

        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (expected_pacing.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result word %0d arrived with none expected: tdata %h tuser %b",
                                 n_results, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_pacing.pop_front();
                    bad  = 1'b0;
                    if (m_axis_tdata[11:0] != want.interval)
                        bad = 1'b1;
                    if (m_axis_tdata[21:12] != want.jitter)
                        bad = 1'b1;
                    if (m_axis_tuser[0] != want.reset_radio)
                        bad = 1'b1;
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("result word %0d: interval exp %0d got %0d, ",
                                     n_results, want.interval, m_axis_tdata[11:0],
                                     "jitter exp %0d got %0d, ",
                                     want.jitter, m_axis_tdata[21:12],
                                     "reset_radio exp %0d got %0d",
                                     want.reset_radio, m_axis_tuser[0]);
                    end
                end

                if (rx_mode_left == 0)
                begin
                    rx_steady    = ($urandom_range(0, 2) == 0);
                    rx_mode_left = $urandom_range(10, 50);
                end
                rx_mode_left--;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 14);
                if (n_results == 150 || n_results == 800)
                    hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait > 0 && m_axis_tvalid)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Stimulus plan and end of run
    initial
    begin : plan_block
        int target_plan[PHASES];
        int t;
        int band;
        int total;
        int lo;
        int hi;
        int oth;
        int p;
        int i;
        int k;

        // directed windows at the reset target of 20, interval 875
        add_window(5, 0, 3);            // large step, peer floor 666
        add_window(1, 0, 0);            // well under target: halve
        add_window(8, 2, 0);            // medium step, no-peer floor 1000
        add_window(9, 9, 200);          // more peers than target: floor 4000
        add_window(1023, 1023, 255);    // saturating slow-down
        add_window(19, 0, 1);           // in band: unchanged
        add_window(10, 10, 1);          // exactly on target: unchanged
        add_window(3, 7, 5);            // we sent more than we heard: no step
        add_window(0, 0, 0);            // four silent windows raise the reset
        add_window(0, 5, 0);
        add_window(0, 1023, 255);
        add_window(0, 0, 7);
        add_window(0, 0, 0);            // counting starts again
        add_window(21, 0, 0);           // just over target
        for (i = 0; i < 5; i++)
            add_window(1, 0, 1);        // halve down to the interval and jitter floors
        add_control(ACT_TARGET, 1023);
        add_window(940, 0, 4);          // close under target: fine step
        add_window(600, 300, 255);
        add_window(1023, 1023, 1);
        add_window(500, 0, 2);
        add_control(ACT_TARGET, 0);     // zero target acts as one
        add_window(1, 0, 0);
        add_window(1, 1, 3);
        add_window(0, 0, 0);

        target_plan[0] = 20;
        target_plan[1] = 1;
        target_plan[2] = 1023;
        target_plan[3] = 0;
        target_plan[4] = $urandom_range(1, 1023);
        target_plan[5] = $urandom_range(1, 40);
        target_plan[6] = $urandom_range(1, 1023);
        target_plan[7] = 512;
        target_plan[8] = $urandom_range(41, 1023);
        target_plan[9] = $urandom_range(1, 1023);

        for (p = 0; p < PHASES; p++)
        begin
            add_control(ACT_TARGET, target_plan[p]);
            t = (target_plan[p] == 0) ? 1 : target_plan[p];
            for (i = 0; i < PHASE_WINDOWS; i++)
            begin
                // sender stops until everything is back, mid-phase
                if ((p == 3 || p == 7) && i == PHASE_WINDOWS / 2)
                    add_control(ACT_DRAIN, 0);
                band = $urandom_range(0, 9);
                case (band)
                    2:       begin lo = 0;                   hi = (t - 1) / 4;         end
                    3, 4:    begin lo = (t + 3) / 4;         hi = (19 * t - 1) / 20;   end
                    5:       begin lo = (19 * t + 19) / 20;  hi = t;                   end
                    6, 7:    begin lo = t + 1;               hi = 3 * t + 5;           end
                    default: begin lo = 0;                   hi = 2046;                end
                endcase
                if (hi > 2046)
                    hi = 2046;
                if (lo > hi)
                    lo = hi;
                if (band == 8)
                begin
                    // a run of silent windows
                    for (k = $urandom_range(1, 6); k > 0; k--)
                        add_window(0, $urandom_range(0, 1023), $urandom_range(0, 255));
                end
                else if (band <= 1)
                    add_window($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 255));
                else
                begin
                    total = (band == 9) ? $urandom_range(0, 12) : $urandom_range(lo, hi);
                    oth   = $urandom_range((total > 1023) ? total - 1023 : 0,
                                           (total < 1023) ? total : 1023);
                    add_window(oth, total - oth,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 255));
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ticks.size() != 0 || have_tick || s_axis_tvalid || cfg_valid ||
               expected_pacing.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_pacing.size() != 0)
        begin
            fail_count++;
            $display("%0d expected result words never arrived", expected_pacing.size());
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run (~3 ms)
    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
